// ===== sv/gdc_pkg.sv =====
// shared types, constants and codes for the gesture direction classifier
`default_nettype none

package gdc_pkg;

  // accumulator width and defaults for zero configuration values
  localparam int unsigned SUM_WIDTH     = 32;
  localparam int unsigned THR_WIDTH     = 16;
  localparam int unsigned RATIO_WIDTH   = 8;
  localparam int unsigned TYPE_WIDTH    = 8;
  localparam int unsigned DELTA_WIDTH   = 16;
  localparam int unsigned TOTAL_WIDTH   = 32;
  localparam int unsigned CFG_WIDTH     = 16;
  localparam int unsigned PROD_WIDTH    = SUM_WIDTH + RATIO_WIDTH;

  localparam logic [THR_WIDTH-1:0]   DEF_THRESHOLD = THR_WIDTH'(70);
  localparam logic [RATIO_WIDTH-1:0] DEF_NUM       = RATIO_WIDTH'(13);
  localparam logic [RATIO_WIDTH-1:0] DEF_DEN       = RATIO_WIDTH'(10);

  // input word kinds
  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_DELTA  = 2'd1,
    KIND_CANCEL = 2'd2,
    KIND_FINISH = 2'd3
  } kind_t;

  // classified direction codes
  typedef enum logic [2:0] {
    DIR_NONE  = 3'd0,
    DIR_LEFT  = 3'd1,
    DIR_RIGHT = 3'd2,
    DIR_UP    = 3'd3,
    DIR_DOWN  = 3'd4
  } dir_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_NUMERATOR = 2'd1,
    CFG_DENOMINATOR = 2'd2,
    CFG_PAN_TYPE  = 2'd3
  } cfg_idx_t;

  // effective configuration values (zero already mapped to defaults)
  typedef struct packed {
    logic [THR_WIDTH-1:0]   thr;
    logic [RATIO_WIDTH-1:0] num;
    logic [RATIO_WIDTH-1:0] den;
    logic [TYPE_WIDTH-1:0]  pan_code;
  } cfg_t;

  // thresholds latched for the running gesture
  typedef struct packed {
    logic [THR_WIDTH-1:0]   thr;
    logic [RATIO_WIDTH-1:0] num;
    logic [RATIO_WIDTH-1:0] den;
  } gcfg_t;

  // one result word
  typedef struct packed {
    logic                          gesture_active;
    logic [TYPE_WIDTH-1:0]         current_type;
    logic                          pan_now;
    logic                          finished;
    dir_t                          direction;
    logic signed [TOTAL_WIDTH-1:0] total_x;
    logic signed [TOTAL_WIDTH-1:0] total_y;
    logic                          pan_latched;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/gdc_cfg.sv =====
// configuration registers with zero-means-default mapping
`default_nettype none

module gdc_cfg
  import gdc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [CFG_WIDTH-1:0] cfg_wdata,
  output cfg_t                      cfg
);

  logic [THR_WIDTH-1:0]   thr_r;
  logic [RATIO_WIDTH-1:0] num_r;
  logic [RATIO_WIDTH-1:0] den_r;
  logic [TYPE_WIDTH-1:0]  pan_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= DEF_THRESHOLD;
      num_r <= DEF_NUM;
      den_r <= DEF_DEN;
      pan_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_THRESHOLD:   thr_r <= cfg_wdata[THR_WIDTH-1:0];
        CFG_NUMERATOR:   num_r <= cfg_wdata[RATIO_WIDTH-1:0];
        CFG_DENOMINATOR: den_r <= cfg_wdata[RATIO_WIDTH-1:0];
        CFG_PAN_TYPE:    pan_r <= cfg_wdata[TYPE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // zero values fall back to defaults
  always_comb begin
    cfg.thr      = (thr_r != '0) ? thr_r : DEF_THRESHOLD;
    cfg.num      = (num_r != '0) ? num_r : DEF_NUM;
    cfg.den      = (den_r != '0) ? den_r : DEF_DEN;
    cfg.pan_code = pan_r;
  end

endmodule

`default_nettype wire

// ===== sv/gdc_classify.sv =====
// direction decision from the accumulated sums
`default_nettype none

module gdc_classify
  import gdc_pkg::*;
(
  input  wire logic signed [SUM_WIDTH-1:0] sum_x,
  input  wire logic signed [SUM_WIDTH-1:0] sum_y,
  input  wire gcfg_t                       gcfg,
  output dir_t                             direction
);

  logic [SUM_WIDTH-1:0]  ax;
  logic [SUM_WIDTH-1:0]  ay;
  logic [SUM_WIDTH-1:0]  thr_ext;
  logic [PROD_WIDTH-1:0] ax_den;
  logic [PROD_WIDTH-1:0] ay_num;
  logic [PROD_WIDTH-1:0] ay_den;
  logic [PROD_WIDTH-1:0] ax_num;
  logic                  below;

  // magnitudes, exact for the most negative value
  always_comb begin
    ax      = sum_x[SUM_WIDTH-1] ? (~sum_x + 1'b1) : sum_x;
    ay      = sum_y[SUM_WIDTH-1] ? (~sum_y + 1'b1) : sum_y;
    thr_ext = SUM_WIDTH'(gcfg.thr);
    below   = (ax < thr_ext) && (ay < thr_ext);
  end

  // exact cross products for the dominance test
  always_comb begin
    ax_den = PROD_WIDTH'(ax) * PROD_WIDTH'(gcfg.den);
    ay_num = PROD_WIDTH'(ay) * PROD_WIDTH'(gcfg.num);
    ay_den = PROD_WIDTH'(ay) * PROD_WIDTH'(gcfg.den);
    ax_num = PROD_WIDTH'(ax) * PROD_WIDTH'(gcfg.num);
  end

  // pick the dominant axis
  always_comb begin
    priority if (below) begin
      direction = DIR_NONE;
    end else if (ax_den > ay_num) begin
      direction = sum_x[SUM_WIDTH-1] ? DIR_LEFT : DIR_RIGHT;
    end else if (ay_den > ax_num) begin
      direction = sum_y[SUM_WIDTH-1] ? DIR_UP : DIR_DOWN;
    end else begin
      direction = DIR_NONE;
    end
  end

endmodule

`default_nettype wire

// ===== sv/gdc_track.sv =====
// gesture state, saturating sums, pan latch and result formation
`default_nettype none

module gdc_track
  import gdc_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step,
  input  wire kind_t                         kind,
  input  wire logic [TYPE_WIDTH-1:0]         gesture_type,
  input  wire logic signed [DELTA_WIDTH-1:0] delta_x,
  input  wire logic signed [DELTA_WIDTH-1:0] delta_y,
  input  wire cfg_t                          cfg,
  output res_t                               res
);

  localparam int unsigned SW1 = SUM_WIDTH + 1;

  logic                        active_r, active_nxt;
  logic [TYPE_WIDTH-1:0]       type_r, type_nxt;
  logic signed [SUM_WIDTH-1:0] sum_x_r, sum_x_nxt;
  logic signed [SUM_WIDTH-1:0] sum_y_r, sum_y_nxt;
  logic                        pan_r, pan_nxt;
  gcfg_t                       gcfg_r, gcfg_nxt;

  logic signed [SW1-1:0]       wide_x;
  logic signed [SW1-1:0]       wide_y;
  logic signed [SUM_WIDTH-1:0] sat_x;
  logic signed [SUM_WIDTH-1:0] sat_y;
  logic [SUM_WIDTH-1:0]        mag_x;
  logic [SUM_WIDTH-1:0]        mag_y;
  logic                        pan_hit;
  dir_t                        fin_dir;

  // saturating accumulate
  always_comb begin
    wide_x = SW1'(sum_x_r) + SW1'(delta_x);
    wide_y = SW1'(sum_y_r) + SW1'(delta_y);
    if (wide_x[SW1-1] != wide_x[SW1-2]) begin
      sat_x = {wide_x[SW1-1], {(SUM_WIDTH-1){~wide_x[SW1-1]}}};
    end else begin
      sat_x = wide_x[SUM_WIDTH-1:0];
    end
    if (wide_y[SW1-1] != wide_y[SW1-2]) begin
      sat_y = {wide_y[SW1-1], {(SUM_WIDTH-1){~wide_y[SW1-1]}}};
    end else begin
      sat_y = wide_y[SUM_WIDTH-1:0];
    end
    mag_x   = sat_x[SUM_WIDTH-1] ? (~sat_x + 1'b1) : sat_x;
    mag_y   = sat_y[SUM_WIDTH-1] ? (~sat_y + 1'b1) : sat_y;
    pan_hit = (type_r == cfg.pan_code) &&
              ((mag_x >= SUM_WIDTH'(gcfg_r.thr)) || (mag_y >= SUM_WIDTH'(gcfg_r.thr)));
  end

  // direction of the gesture as it stands
  gdc_classify u_classify (
    .sum_x     (sum_x_r),
    .sum_y     (sum_y_r),
    .gcfg      (gcfg_r),
    .direction (fin_dir)
  );

  // next state per word kind
  always_comb begin
    active_nxt = active_r;
    type_nxt   = type_r;
    sum_x_nxt  = sum_x_r;
    sum_y_nxt  = sum_y_r;
    pan_nxt    = pan_r;
    gcfg_nxt   = gcfg_r;
    unique case (kind)
      KIND_START: begin
        active_nxt   = 1'b1;
        type_nxt     = gesture_type;
        sum_x_nxt    = '0;
        sum_y_nxt    = '0;
        pan_nxt      = 1'b0;
        gcfg_nxt.thr = cfg.thr;
        gcfg_nxt.num = cfg.num;
        gcfg_nxt.den = cfg.den;
      end
      KIND_DELTA: begin
        if (active_r) begin
          sum_x_nxt = sat_x;
          sum_y_nxt = sat_y;
          pan_nxt   = pan_r | pan_hit;
        end
      end
      KIND_CANCEL, KIND_FINISH: begin
        active_nxt = 1'b0;
        type_nxt   = '0;
        sum_x_nxt  = '0;
        sum_y_nxt  = '0;
        pan_nxt    = 1'b0;
      end
      default: ;
    endcase
  end

  // result word for this step
  always_comb begin
    res                = '0;
    res.gesture_active = active_nxt;
    res.current_type   = type_nxt;
    res.pan_now        = active_nxt && (type_nxt == cfg.pan_code) && pan_nxt;
    res.direction      = DIR_NONE;
    if (kind == KIND_FINISH) begin
      res.finished    = 1'b1;
      res.direction   = fin_dir;
      res.total_x     = TOTAL_WIDTH'(sum_x_r);
      res.total_y     = TOTAL_WIDTH'(sum_y_r);
      res.pan_latched = pan_r;
    end
  end

  // gesture state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      type_r     <= '0;
      sum_x_r    <= '0;
      sum_y_r    <= '0;
      pan_r      <= 1'b0;
      gcfg_r.thr <= DEF_THRESHOLD;
      gcfg_r.num <= DEF_NUM;
      gcfg_r.den <= DEF_DEN;
    end else if (step) begin
      active_r <= active_nxt;
      type_r   <= type_nxt;
      sum_x_r  <= sum_x_nxt;
      sum_y_r  <= sum_y_nxt;
      pan_r    <= pan_nxt;
      gcfg_r   <= gcfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pointer_gesture_direction_classifier_core.sv =====
// gesture direction classifier: an accepted word is held in the input register, its result in the result register
// throughput one word per cycle while the output is not stalled; input register, one pass of logic, result register
// the input side keeps taking words while a result waits, until both stages are full
// synchronous active-low reset clears the gesture, empties both stages
// and loads configuration defaults 70, 13, 10 and pan type 0
`default_nettype none

module pointer_gesture_direction_classifier_core
  import gdc_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [CFG_WIDTH-1:0]          cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_kind,
  input  wire logic [TYPE_WIDTH-1:0]         in_gesture_type,
  input  wire logic signed [DELTA_WIDTH-1:0] in_delta_x,
  input  wire logic signed [DELTA_WIDTH-1:0] in_delta_y,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_gesture_active,
  output logic [TYPE_WIDTH-1:0]              out_current_type,
  output logic                               out_pan_now,
  output logic                               out_finished,
  output logic [2:0]                         out_direction,
  output logic signed [TOTAL_WIDTH-1:0]      out_total_x,
  output logic signed [TOTAL_WIDTH-1:0]      out_total_y,
  output logic                               out_pan_latched
);

  logic                          s1_valid_r, s1_valid_nxt;
  kind_t                         s1_kind_r;
  logic [TYPE_WIDTH-1:0]         s1_type_r;
  logic signed [DELTA_WIDTH-1:0] s1_dx_r;
  logic signed [DELTA_WIDTH-1:0] s1_dy_r;
  logic                          out_valid_r, out_valid_nxt;
  res_t                          res_r;
  res_t                          res_calc;
  cfg_t                          cfg;
  logic                          advance;
  logic                          step;
  logic                          in_take;

  // configuration registers
  gdc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // pipeline flow control
  always_comb begin
    advance       = !out_valid_r || out_ready;
    step          = s1_valid_r && advance;
    in_ready      = !s1_valid_r || advance;
    in_take       = in_valid && in_ready;
    s1_valid_nxt  = in_take ? 1'b1 : (step ? 1'b0 : s1_valid_r);
    out_valid_nxt = step ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input word register
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_kind_r <= kind_t'(in_kind);
      s1_type_r <= in_gesture_type;
      s1_dx_r   <= in_delta_x;
      s1_dy_r   <= in_delta_y;
    end
  end

  // gesture tracking and classification
  gdc_track u_track (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .kind         (s1_kind_r),
    .gesture_type (s1_type_r),
    .delta_x      (s1_dx_r),
    .delta_y      (s1_dy_r),
    .cfg          (cfg),
    .res          (res_calc)
  );

  // result register
  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_calc;
    end
  end

  // output ports
  assign out_valid          = out_valid_r;
  assign out_gesture_active = res_r.gesture_active;
  assign out_current_type   = res_r.current_type;
  assign out_pan_now        = res_r.pan_now;
  assign out_finished       = res_r.finished;
  assign out_direction      = res_r.direction;
  assign out_total_x        = res_r.total_x;
  assign out_total_y        = res_r.total_y;
  assign out_pan_latched    = res_r.pan_latched;

  // a finish always leaves the block idle
  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.finished) |-> (!res_r.gesture_active && res_r.current_type == '0))
    else $error("finish word left a gesture active");

  // snapshot fields are zero outside a finish
  a_no_snapshot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.finished) |->
      (res_r.direction == DIR_NONE && res_r.total_x == '0 &&
       res_r.total_y == '0 && !res_r.pan_latched))
    else $error("snapshot fields set on a non-finish word");

  // pan indication needs an active gesture
  a_pan_active: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.pan_now) |-> res_r.gesture_active)
    else $error("pan reported while idle");

  // back pressure only when both stages hold a word
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled with room in the pipeline");

  // a stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(res_r)))
    else $error("stalled result changed");

endmodule

`default_nettype wire
